FILE: rtl/sthit_pkg.sv
// Shared types, constants and microcode for the segment/triangle nearest-hit block.
package sthit_pkg;

  localparam int COORD_BITS = 32;
  // Working width: the inside-test dot products are the widest values.
  localparam int WW         = 4 * COORD_BITS + 16;
  // |quotient| never exceeds |start - end|, so two bits above a coordinate do.
  localparam int DIV_BITS   = COORD_BITS + 2;
  localparam int DSH_W      = WW + DIV_BITS - 1;
  localparam int CNT_W      = $clog2(DIV_BITS);
  localparam int DIST_SHIFT = (2 * COORD_BITS > 62) ? (2 * COORD_BITS - 62) : 0;
  localparam int KEY_BITS   = 64;
  localparam int CFG_IW     = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner0_z;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner1_z;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner2_z;
    logic                         last_triangle;
  } facet_t;

  typedef struct packed {
    logic                         any_hit_out;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
  } hit_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SX, CFG_SY, CFG_SZ, CFG_EX, CFG_EY, CFG_EZ
  } cfg_idx_t;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT} state_t;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_SKIPPOS, OP_SKIPZERO, OP_SKIPNP, OP_KEEP, OP_END
  } op_t;

  localparam int RF_AW    = 6;
  localparam int RF_DEPTH = 1 << RF_AW;
  typedef logic [RF_AW-1:0] rf_addr_t;

  // Register file map. Loadable sources share their address with the source.
  localparam rf_addr_t R_P0X  = rf_addr_t'(0);
  localparam rf_addr_t R_P0Y  = rf_addr_t'(1);
  localparam rf_addr_t R_P0Z  = rf_addr_t'(2);
  localparam rf_addr_t R_P1X  = rf_addr_t'(3);
  localparam rf_addr_t R_P1Y  = rf_addr_t'(4);
  localparam rf_addr_t R_P1Z  = rf_addr_t'(5);
  localparam rf_addr_t R_P2X  = rf_addr_t'(6);
  localparam rf_addr_t R_P2Y  = rf_addr_t'(7);
  localparam rf_addr_t R_P2Z  = rf_addr_t'(8);
  localparam rf_addr_t R_SX   = rf_addr_t'(9);
  localparam rf_addr_t R_SY   = rf_addr_t'(10);
  localparam rf_addr_t R_SZ   = rf_addr_t'(11);
  localparam rf_addr_t R_EX   = rf_addr_t'(12);
  localparam rf_addr_t R_EY   = rf_addr_t'(13);
  localparam rf_addr_t R_EZ   = rf_addr_t'(14);
  localparam rf_addr_t R_ZERO = rf_addr_t'(15);
  localparam rf_addr_t R_UX   = rf_addr_t'(16);
  localparam rf_addr_t R_UY   = rf_addr_t'(17);
  localparam rf_addr_t R_UZ   = rf_addr_t'(18);
  localparam rf_addr_t R_VX   = rf_addr_t'(19);
  localparam rf_addr_t R_VY   = rf_addr_t'(20);
  localparam rf_addr_t R_VZ   = rf_addr_t'(21);
  localparam rf_addr_t R_NX   = rf_addr_t'(22);
  localparam rf_addr_t R_NY   = rf_addr_t'(23);
  localparam rf_addr_t R_NZ   = rf_addr_t'(24);
  localparam rf_addr_t R_WX   = rf_addr_t'(25);
  localparam rf_addr_t R_WY   = rf_addr_t'(26);
  localparam rf_addr_t R_WZ   = rf_addr_t'(27);
  localparam rf_addr_t R_T0   = rf_addr_t'(28);
  localparam rf_addr_t R_T1   = rf_addr_t'(29);
  localparam rf_addr_t R_DA   = rf_addr_t'(30);
  localparam rf_addr_t R_DB   = rf_addr_t'(31);
  localparam rf_addr_t R_DEN  = rf_addr_t'(32);
  localparam rf_addr_t R_NB   = rf_addr_t'(33);
  localparam rf_addr_t R_CX   = rf_addr_t'(34);
  localparam rf_addr_t R_CY   = rf_addr_t'(35);
  localparam rf_addr_t R_CZ   = rf_addr_t'(36);
  localparam rf_addr_t R_AX   = rf_addr_t'(37);
  localparam rf_addr_t R_AY   = rf_addr_t'(38);
  localparam rf_addr_t R_AZ   = rf_addr_t'(39);
  localparam rf_addr_t R_BX   = rf_addr_t'(40);
  localparam rf_addr_t R_BY   = rf_addr_t'(41);
  localparam rf_addr_t R_BZ   = rf_addr_t'(42);

  typedef struct packed {
    op_t      op;
    rf_addr_t d;
    rf_addr_t a;
    rf_addr_t b;
  } uop_t;

  typedef struct packed {
    logic start;
    logic div;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [WW-1:0] result;
  } arith_rsp_t;

  function automatic uop_t mk(op_t op, rf_addr_t d, rf_addr_t a, rf_addr_t b);
    uop_t u;
    u.op = op;
    u.d  = d;
    u.a  = a;
    u.b  = b;
    return u;
  endfunction

  function automatic logic [WW-1:0] sext(logic [COORD_BITS-1:0] x);
    return {{(WW - COORD_BITS){x[COORD_BITS-1]}}, x};
  endfunction

  localparam int UCODE_LEN = 126;
  localparam int PC_W      = $clog2(UCODE_LEN);
  localparam logic [PC_W-1:0] END_PC = PC_W'(UCODE_LEN - 1);

  // The MUL unit walks the bits of operand b, so b is the narrower one.
  localparam uop_t UCODE [UCODE_LEN] = '{
    // load corners, segment and zero
    mk(OP_LD, R_P0X, R_P0X, R_ZERO), mk(OP_LD, R_P0Y, R_P0Y, R_ZERO),
    mk(OP_LD, R_P0Z, R_P0Z, R_ZERO), mk(OP_LD, R_P1X, R_P1X, R_ZERO),
    mk(OP_LD, R_P1Y, R_P1Y, R_ZERO), mk(OP_LD, R_P1Z, R_P1Z, R_ZERO),
    mk(OP_LD, R_P2X, R_P2X, R_ZERO), mk(OP_LD, R_P2Y, R_P2Y, R_ZERO),
    mk(OP_LD, R_P2Z, R_P2Z, R_ZERO), mk(OP_LD, R_SX, R_SX, R_ZERO),
    mk(OP_LD, R_SY, R_SY, R_ZERO),   mk(OP_LD, R_SZ, R_SZ, R_ZERO),
    mk(OP_LD, R_EX, R_EX, R_ZERO),   mk(OP_LD, R_EY, R_EY, R_ZERO),
    mk(OP_LD, R_EZ, R_EZ, R_ZERO),   mk(OP_LD, R_ZERO, R_ZERO, R_ZERO),
    // U = P1 - P0, V = P2 - P0
    mk(OP_SUB, R_UX, R_P1X, R_P0X), mk(OP_SUB, R_UY, R_P1Y, R_P0Y),
    mk(OP_SUB, R_UZ, R_P1Z, R_P0Z),
    mk(OP_SUB, R_VX, R_P2X, R_P0X), mk(OP_SUB, R_VY, R_P2Y, R_P0Y),
    mk(OP_SUB, R_VZ, R_P2Z, R_P0Z),
    // N = U x V
    mk(OP_MUL, R_T0, R_UY, R_VZ), mk(OP_MUL, R_T1, R_UZ, R_VY), mk(OP_SUB, R_NX, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UZ, R_VX), mk(OP_MUL, R_T1, R_UX, R_VZ), mk(OP_SUB, R_NY, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UX, R_VY), mk(OP_MUL, R_T1, R_UY, R_VX), mk(OP_SUB, R_NZ, R_T0, R_T1),
    // da = N . (S - P0)
    mk(OP_SUB, R_WX, R_SX, R_P0X), mk(OP_SUB, R_WY, R_SY, R_P0Y),
    mk(OP_SUB, R_WZ, R_SZ, R_P0Z),
    mk(OP_MUL, R_T0, R_NX, R_WX), mk(OP_MUL, R_T1, R_NY, R_WY), mk(OP_ADD, R_T0, R_T0, R_T1),
    mk(OP_MUL, R_T1, R_NZ, R_WZ), mk(OP_ADD, R_DA, R_T0, R_T1),
    // db = N . (E - P0)
    mk(OP_SUB, R_WX, R_EX, R_P0X), mk(OP_SUB, R_WY, R_EY, R_P0Y),
    mk(OP_SUB, R_WZ, R_EZ, R_P0Z),
    mk(OP_MUL, R_T0, R_NX, R_WX), mk(OP_MUL, R_T1, R_NY, R_WY), mk(OP_ADD, R_T0, R_T0, R_T1),
    mk(OP_MUL, R_T1, R_NZ, R_WZ), mk(OP_ADD, R_DB, R_T0, R_T1),
    // straddle, denominator, -db
    mk(OP_SKIPPOS, R_ZERO, R_DA, R_DB),
    mk(OP_SUB, R_DEN, R_DA, R_DB),
    mk(OP_SKIPZERO, R_ZERO, R_DEN, R_ZERO),
    mk(OP_SUB, R_NB, R_ZERO, R_DB),
    // W = S - E, C = E + W * (-db) / den
    mk(OP_SUB, R_WX, R_SX, R_EX), mk(OP_SUB, R_WY, R_SY, R_EY),
    mk(OP_SUB, R_WZ, R_SZ, R_EZ),
    mk(OP_MUL, R_T0, R_NB, R_WX), mk(OP_DIV, R_T0, R_T0, R_DEN), mk(OP_ADD, R_CX, R_EX, R_T0),
    mk(OP_MUL, R_T0, R_NB, R_WY), mk(OP_DIV, R_T0, R_T0, R_DEN), mk(OP_ADD, R_CY, R_EY, R_T0),
    mk(OP_MUL, R_T0, R_NB, R_WZ), mk(OP_DIV, R_T0, R_T0, R_DEN), mk(OP_ADD, R_CZ, R_EZ, R_T0),
    // A = (P1 - P0) x (C - P0)
    mk(OP_SUB, R_WX, R_CX, R_P0X), mk(OP_SUB, R_WY, R_CY, R_P0Y),
    mk(OP_SUB, R_WZ, R_CZ, R_P0Z),
    mk(OP_MUL, R_T0, R_UY, R_WZ), mk(OP_MUL, R_T1, R_UZ, R_WY), mk(OP_SUB, R_AX, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UZ, R_WX), mk(OP_MUL, R_T1, R_UX, R_WZ), mk(OP_SUB, R_AY, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UX, R_WY), mk(OP_MUL, R_T1, R_UY, R_WX), mk(OP_SUB, R_AZ, R_T0, R_T1),
    // B = (P2 - P1) x (C - P1)
    mk(OP_SUB, R_UX, R_P2X, R_P1X), mk(OP_SUB, R_UY, R_P2Y, R_P1Y),
    mk(OP_SUB, R_UZ, R_P2Z, R_P1Z),
    mk(OP_SUB, R_WX, R_CX, R_P1X), mk(OP_SUB, R_WY, R_CY, R_P1Y),
    mk(OP_SUB, R_WZ, R_CZ, R_P1Z),
    mk(OP_MUL, R_T0, R_UY, R_WZ), mk(OP_MUL, R_T1, R_UZ, R_WY), mk(OP_SUB, R_BX, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UZ, R_WX), mk(OP_MUL, R_T1, R_UX, R_WZ), mk(OP_SUB, R_BY, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UX, R_WY), mk(OP_MUL, R_T1, R_UY, R_WX), mk(OP_SUB, R_BZ, R_T0, R_T1),
    // DA = A . B
    mk(OP_MUL, R_T0, R_AX, R_BX), mk(OP_MUL, R_T1, R_AY, R_BY), mk(OP_ADD, R_T0, R_T0, R_T1),
    mk(OP_MUL, R_T1, R_AZ, R_BZ), mk(OP_ADD, R_DA, R_T0, R_T1),
    // K = (P0 - P2) x (C - P2), held in B
    mk(OP_SUB, R_UX, R_P0X, R_P2X), mk(OP_SUB, R_UY, R_P0Y, R_P2Y),
    mk(OP_SUB, R_UZ, R_P0Z, R_P2Z),
    mk(OP_SUB, R_WX, R_CX, R_P2X), mk(OP_SUB, R_WY, R_CY, R_P2Y),
    mk(OP_SUB, R_WZ, R_CZ, R_P2Z),
    mk(OP_MUL, R_T0, R_UY, R_WZ), mk(OP_MUL, R_T1, R_UZ, R_WY), mk(OP_SUB, R_BX, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UZ, R_WX), mk(OP_MUL, R_T1, R_UX, R_WZ), mk(OP_SUB, R_BY, R_T0, R_T1),
    mk(OP_MUL, R_T0, R_UX, R_WY), mk(OP_MUL, R_T1, R_UY, R_WX), mk(OP_SUB, R_BZ, R_T0, R_T1),
    // DB = A . K
    mk(OP_MUL, R_T0, R_AX, R_BX), mk(OP_MUL, R_T1, R_AY, R_BY), mk(OP_ADD, R_T0, R_T0, R_T1),
    mk(OP_MUL, R_T1, R_AZ, R_BZ), mk(OP_ADD, R_DB, R_T0, R_T1),
    mk(OP_SKIPNP, R_ZERO, R_DA, R_DB),
    // DA = |C - S|^2
    mk(OP_SUB, R_WX, R_CX, R_SX), mk(OP_SUB, R_WY, R_CY, R_SY),
    mk(OP_SUB, R_WZ, R_CZ, R_SZ),
    mk(OP_MUL, R_T0, R_WX, R_WX), mk(OP_MUL, R_T1, R_WY, R_WY), mk(OP_ADD, R_T0, R_T0, R_T1),
    mk(OP_MUL, R_T1, R_WZ, R_WZ), mk(OP_ADD, R_DA, R_T0, R_T1),
    mk(OP_KEEP, R_ZERO, R_DA, R_ZERO),
    mk(OP_END, R_ZERO, R_ZERO, R_ZERO)
  };

endpackage

FILE: rtl/sthit_arith.sv
// Shared shift-add multiplier and restoring divider for the nearest-hit sequencer.
module sthit_arith (
  input  logic                     clk,
  input  logic                     rst,
  input  sthit_pkg::arith_req_t    req,
  input  logic [sthit_pkg::WW-1:0] a,
  input  logic [sthit_pkg::WW-1:0] b,
  output sthit_pkg::arith_rsp_t    rsp
);

  logic                              busy;
  logic                              is_div;
  logic                              neg;
  logic                              fin;
  logic [sthit_pkg::WW-1:0]          acc;
  logic [sthit_pkg::WW-1:0]          ma;
  logic [sthit_pkg::WW-1:0]          mb;
  logic [sthit_pkg::DSH_W-1:0]       dsh;
  logic [sthit_pkg::CNT_W-1:0]       cnt;
  logic [sthit_pkg::WW-1:0]          mag_a;
  logic [sthit_pkg::WW-1:0]          mag_b;
  logic                              ge;

  assign mag_a = a[sthit_pkg::WW-1] ? (~a + sthit_pkg::WW'(1)) : a;
  assign mag_b = b[sthit_pkg::WW-1] ? (~b + sthit_pkg::WW'(1)) : b;
  assign ge    = {{(sthit_pkg::DIV_BITS-1){1'b0}}, acc} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.div;
        neg    <= a[sthit_pkg::WW-1] ^ b[sthit_pkg::WW-1];
        fin    <= 1'b0;
        acc    <= req.div ? mag_a : '0;
        ma     <= mag_a;
        mb     <= req.div ? '0 : mag_b;
        dsh    <= {mag_b, {(sthit_pkg::DIV_BITS-1){1'b0}}};
        cnt    <= sthit_pkg::CNT_W'(sthit_pkg::DIV_BITS - 1);
      end else if (busy) begin
        if (!is_div) begin
          // one multiplier bit per cycle, stops once b runs out of ones
          if (mb == '0) begin
            busy       <= 1'b0;
            rsp.done   <= 1'b1;
            rsp.result <= neg ? (~acc + sthit_pkg::WW'(1)) : acc;
          end else begin
            if (mb[0]) acc <= acc + ma;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end else if (fin) begin
          busy       <= 1'b0;
          rsp.done   <= 1'b1;
          rsp.result <= neg ? (~mb + sthit_pkg::WW'(1)) : mb;
        end else begin
          // restoring step: quotient bit shifts into mb
          if (ge) acc <= acc - dsh[sthit_pkg::WW-1:0];
          mb  <= {mb[sthit_pkg::WW-2:0], ge};
          dsh <= dsh >> 1;
          if (cnt == '0) fin <= 1'b1;
          else           cnt <= cnt - sthit_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/segment_triangle_nearest_hit.sv
// Top level: microcoded segment/triangle crossing test with nearest-hit tracking.
//
// Usage:
// - Load the segment with wr_en/wr_index/wr_data (index 0..2 start x/y/z,
//   3..5 end x/y/z, signed Q16.16) while the block is idle.
// - Send triangles on facet (valid/stall). facet_stall is high from the
//   accept until the triangle's microprogram ends; one item is in work.
// - The item with last_triangle set produces one hit item: any_hit_out and
//   the crossing point nearest the segment start (zeros if none). The
//   running best is then cleared for the next query.
// Execution: each microinstruction passes through a register-file fetch
// state and an execute state; multiplies run on one shift-add unit at one bit
// of the second operand per cycle, and divides share that unit. A triangle
// that misses the plane ends early. The multiplier dominates.
// Results sit in an output register: a stalled hit item holds, and the block
// keeps taking triangles; only a second final result waits for the slot.
// Reset (rst, synchronous) clears the segment to zero, the best hit, and
// returns the sequencer to idle.
module segment_triangle_nearest_hit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             facet_valid,
  output logic                             facet_stall,
  input  sthit_pkg::facet_t                facet,
  output logic                             hit_valid,
  input  logic                             hit_stall,
  output sthit_pkg::hit_t                  hit,
  input  logic                             wr_en,
  input  logic [sthit_pkg::CFG_IW-1:0]     wr_index,
  input  logic [sthit_pkg::COORD_BITS-1:0] wr_data
);

  sthit_pkg::state_t                  state, state_next;
  logic [sthit_pkg::PC_W-1:0]         pc, pc_next;
  sthit_pkg::uop_t                    uop;
  sthit_pkg::facet_t                  item;

  logic [sthit_pkg::COORD_BITS-1:0]   seg_start_x, seg_start_y, seg_start_z;
  logic [sthit_pkg::COORD_BITS-1:0]   seg_end_x, seg_end_y, seg_end_z;

  // register file: one write port, two registered read ports
  logic [sthit_pkg::WW-1:0]           rf [sthit_pkg::RF_DEPTH];
  logic [sthit_pkg::WW-1:0]           rd_a, rd_b;
  logic                               rf_we;
  sthit_pkg::rf_addr_t                rf_waddr;
  logic [sthit_pkg::WW-1:0]           rf_wdata;
  logic [sthit_pkg::WW-1:0]           ld_val;

  sthit_pkg::arith_req_t              areq;
  sthit_pkg::arith_rsp_t              arsp;

  logic                               hit_seen;
  logic [sthit_pkg::KEY_BITS-1:0]     best_dist_sq;
  logic [sthit_pkg::COORD_BITS-1:0]   best_px, best_py, best_pz;
  logic [sthit_pkg::COORD_BITS-1:0]   cand_x, cand_y, cand_z;
  logic [sthit_pkg::KEY_BITS-1:0]     key;

  logic item_take, keep_en, emit;
  logic pos_a, pos_b, neg_a, neg_b, zero_a;

  assign uop         = sthit_pkg::UCODE[pc];
  assign facet_stall = (state != sthit_pkg::ST_IDLE);

  assign zero_a = (rd_a == '0);
  assign neg_a  = rd_a[sthit_pkg::WW-1];
  assign neg_b  = rd_b[sthit_pkg::WW-1];
  assign pos_a  = !neg_a && !zero_a;
  assign pos_b  = !neg_b && (rd_b != '0);
  assign key    = rd_a[sthit_pkg::DIST_SHIFT + sthit_pkg::KEY_BITS - 1:sthit_pkg::DIST_SHIFT];

  sthit_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .a   (rd_a),
    .b   (rd_b),
    .rsp (arsp)
  );

  // load sources sit at the same register-file address they fill
  always_comb begin
    unique case (uop.a)
      sthit_pkg::R_P0X: ld_val = sthit_pkg::sext(item.corner0_x);
      sthit_pkg::R_P0Y: ld_val = sthit_pkg::sext(item.corner0_y);
      sthit_pkg::R_P0Z: ld_val = sthit_pkg::sext(item.corner0_z);
      sthit_pkg::R_P1X: ld_val = sthit_pkg::sext(item.corner1_x);
      sthit_pkg::R_P1Y: ld_val = sthit_pkg::sext(item.corner1_y);
      sthit_pkg::R_P1Z: ld_val = sthit_pkg::sext(item.corner1_z);
      sthit_pkg::R_P2X: ld_val = sthit_pkg::sext(item.corner2_x);
      sthit_pkg::R_P2Y: ld_val = sthit_pkg::sext(item.corner2_y);
      sthit_pkg::R_P2Z: ld_val = sthit_pkg::sext(item.corner2_z);
      sthit_pkg::R_SX:  ld_val = sthit_pkg::sext(seg_start_x);
      sthit_pkg::R_SY:  ld_val = sthit_pkg::sext(seg_start_y);
      sthit_pkg::R_SZ:  ld_val = sthit_pkg::sext(seg_start_z);
      sthit_pkg::R_EX:  ld_val = sthit_pkg::sext(seg_end_x);
      sthit_pkg::R_EY:  ld_val = sthit_pkg::sext(seg_end_y);
      sthit_pkg::R_EZ:  ld_val = sthit_pkg::sext(seg_end_z);
      default:          ld_val = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    pc_next    = pc;
    rf_we      = 1'b0;
    rf_waddr   = uop.d;
    rf_wdata   = ld_val;
    areq       = '0;
    item_take  = 1'b0;
    keep_en    = 1'b0;
    emit       = 1'b0;
    unique case (state)
      sthit_pkg::ST_IDLE: begin
        if (facet_valid) begin
          item_take  = 1'b1;
          pc_next    = '0;
          state_next = sthit_pkg::ST_FETCH;
        end
      end
      sthit_pkg::ST_FETCH: begin
        state_next = sthit_pkg::ST_EXEC;
      end
      sthit_pkg::ST_EXEC: begin
        state_next = sthit_pkg::ST_FETCH;
        pc_next    = pc + sthit_pkg::PC_W'(1);
        unique case (uop.op) inside
          sthit_pkg::OP_LD: begin
            rf_we = 1'b1;
          end
          sthit_pkg::OP_ADD: begin
            rf_we    = 1'b1;
            rf_wdata = rd_a + rd_b;
          end
          sthit_pkg::OP_SUB: begin
            rf_we    = 1'b1;
            rf_wdata = rd_a - rd_b;
          end
          sthit_pkg::OP_MUL, sthit_pkg::OP_DIV: begin
            areq.start = 1'b1;
            areq.div   = (uop.op == sthit_pkg::OP_DIV);
            pc_next    = pc;
            state_next = sthit_pkg::ST_WAIT;
          end
          sthit_pkg::OP_SKIPPOS: begin
            // both plane distances on the same side: no crossing
            if ((pos_a && pos_b) || (neg_a && neg_b)) pc_next = sthit_pkg::END_PC;
          end
          sthit_pkg::OP_SKIPZERO: begin
            if (zero_a) pc_next = sthit_pkg::END_PC;
          end
          sthit_pkg::OP_SKIPNP: begin
            // point must be strictly inside all edges
            if (!(pos_a && pos_b)) pc_next = sthit_pkg::END_PC;
          end
          sthit_pkg::OP_KEEP: begin
            keep_en = 1'b1;
          end
          sthit_pkg::OP_END: begin
            pc_next = pc;
            if (!item.last_triangle) begin
              state_next = sthit_pkg::ST_IDLE;
            end else if (!hit_valid || !hit_stall) begin
              emit       = 1'b1;
              state_next = sthit_pkg::ST_IDLE;
            end else begin
              state_next = sthit_pkg::ST_EXEC;
            end
          end
          default: begin
            state_next = sthit_pkg::ST_IDLE;
          end
        endcase
      end
      sthit_pkg::ST_WAIT: begin
        if (arsp.done) begin
          rf_we      = 1'b1;
          rf_wdata   = arsp.result;
          pc_next    = pc + sthit_pkg::PC_W'(1);
          state_next = sthit_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = sthit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sthit_pkg::ST_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    rd_a <= rf[uop.a];
    rd_b <= rf[uop.b];
  end

  always_ff @(posedge clk) begin
    if (item_take) item <= facet;
  end

  // crossing point is snooped off the write port as it is produced
  always_ff @(posedge clk) begin
    if (rf_we && rf_waddr == sthit_pkg::R_CX) cand_x <= rf_wdata[sthit_pkg::COORD_BITS-1:0];
    if (rf_we && rf_waddr == sthit_pkg::R_CY) cand_y <= rf_wdata[sthit_pkg::COORD_BITS-1:0];
    if (rf_we && rf_waddr == sthit_pkg::R_CZ) cand_z <= rf_wdata[sthit_pkg::COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_start_z <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
      seg_end_z   <= '0;
    end else if (wr_en) begin
      case (sthit_pkg::cfg_idx_t'(wr_index))
        sthit_pkg::CFG_SX: seg_start_x <= wr_data;
        sthit_pkg::CFG_SY: seg_start_y <= wr_data;
        sthit_pkg::CFG_SZ: seg_start_z <= wr_data;
        sthit_pkg::CFG_EX: seg_end_x   <= wr_data;
        sthit_pkg::CFG_EY: seg_end_y   <= wr_data;
        sthit_pkg::CFG_EZ: seg_end_z   <= wr_data;
        default: ;
      endcase
    end
  end

  // nearest-hit tracking; ties keep the earlier hit
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      hit_seen     <= 1'b0;
      best_dist_sq <= '1;
      best_px      <= '0;
      best_py      <= '0;
      best_pz      <= '0;
    end else if (keep_en) begin
      hit_seen <= 1'b1;
      if (!hit_seen || key < best_dist_sq) begin
        best_dist_sq <= key;
        best_px      <= cand_x;
        best_py      <= cand_y;
        best_pz      <= cand_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (emit) begin
      hit_valid <= 1'b1;
    end else if (!hit_stall) begin
      hit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hit.any_hit_out <= hit_seen;
      hit.near_x      <= best_px;
      hit.near_y      <= best_py;
      hit.near_z      <= best_pz;
    end
  end

endmodule

FILE: rtl/sthit_checker.sv
// Port-level checks for the nearest-hit block, bound to the top level.
module sthit_props (
  input logic              clk,
  input logic              rst,
  input logic              facet_valid,
  input logic              facet_stall,
  input logic              hit_valid,
  input logic              hit_stall,
  input sthit_pkg::hit_t   hit
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("hit item valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && hit_stall |=> hit_valid && $stable(hit))
    else $error("stalled hit item changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit.any_hit_out |-> hit.near_x == '0 && hit.near_y == '0 && hit.near_z == '0)
    else $error("no-hit item carries a nonzero point");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    facet_valid && !facet_stall |=> facet_stall)
    else $error("accepted a triangle without going busy");

endmodule

bind segment_triangle_nearest_hit sthit_props u_sthit_props (.*);
